### rtl/csg_pkg.sv
// ============================================================================
// csg_pkg
// Shared widths, pipeline types and the square-root step for the circle
// span clear generator.
// ============================================================================
package csg_pkg;

    // Field widths
    localparam int CoordW = 10;  // signed center coordinates
    localparam int RadW   = 8;   // unsigned radius
    localparam int RowW   = 6;   // tile row / column index
    localparam int LenW   = 7;   // span length, 0 .. 64
    localparam int SqW    = 16;  // radius squared and root operand
    localparam int ExtW   = 11;  // signed width for row and span arithmetic

    // Root iterations, two per pipeline stage
    localparam int RootSteps    = SqW / 2;
    localparam int StepsPerStg  = 2;
    localparam int RootStages   = RootSteps / StepsPerStg;

    // Item carried through the root pipeline
    typedef struct packed {
        logic [RowW-1:0]          row;
        logic signed [CoordW-1:0] cx;
        logic                     last;
        logic                     miss;
        logic [SqW-1:0]           v;    // remainder
        logic [SqW-1:0]           res;  // partial root
    } t_root;

    // One restoring square-root step; step k uses bit weight 4^(7-k)
    function automatic t_root sqrt_step(input t_root a, input int k);
        t_root          b;
        logic [SqW-1:0] bw;
        logic [SqW:0]   trial;
        b     = a;
        bw    = SqW'(1) << (SqW - 2 - 2 * k);
        trial = {1'b0, a.res} + {1'b0, bw};
        if ({1'b0, a.v} >= trial) begin
            b.v   = a.v - trial[SqW-1:0];
            b.res = (a.res >> 1) + bw;
        end else begin
            b.res = a.res >> 1;
        end
        return b;
    endfunction

endpackage

### rtl/csg_if.sv
// ============================================================================
// csg_if
// Valid/ready channels for circle transactions in and span transactions out.
// ============================================================================
interface csg_in_if
    import csg_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic [RadW-1:0]          radius;

    modport source (output valid, center_x, center_y, radius, input ready);
    modport sink   (input valid, center_x, center_y, radius, output ready);
endinterface

interface csg_out_if
    import csg_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [RowW-1:0] row;
    logic [RowW-1:0] span_start;
    logic [LenW-1:0] span_length;
    logic            span_valid;
    logic            last;

    modport source (output valid, row, span_start, span_length, span_valid, last,
                    input ready);
    modport sink   (input valid, row, span_start, span_length, span_valid, last,
                    output ready);
endinterface

### rtl/circle_span_clear_generator_core.sv
// ============================================================================
// circle_span_clear_generator_core
// Emits one clipped clear span per tile row covered by a circle, and one empty span for a circle that misses the tile.
// ============================================================================
// Works on one circle at a time. After a circle transaction is taken, the row
// sequencer issues one row per cycle while not stalled into a seven-register
// pipeline (row setup, squares, four two-step integer square-root stages, then
// span clip into the output register); a circle covering N tile rows issues N
// row items, and a circle that misses the tile issues one. The next circle is
// taken the cycle after the last row of the current one issues; a circle covers
// up to 64 rows. Downstream back-pressure stalls the whole pipeline.
module circle_span_clear_generator_core
    import csg_pkg::*;
#(
    parameter int TILE_WIDTH  = 64,
    parameter int TILE_HEIGHT = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    csg_in_if.sink    i_in,
    csg_out_if.source o_out
);

    localparam logic signed [ExtW-1:0] WMax = ExtW'(TILE_WIDTH - 1);
    localparam logic signed [ExtW-1:0] WLim = ExtW'(TILE_WIDTH);
    localparam logic signed [ExtW-1:0] HMax = ExtW'(TILE_HEIGHT - 1);

    // Pipeline advance: the output register can take a new item
    logic w_adv;
    assign w_adv = !o_out.valid || o_out.ready;

    // ------------------------------------------------------------------
    // Row sequencer
    // ------------------------------------------------------------------
    logic                     r_busy;
    logic signed [CoordW-1:0] r_cx;
    logic signed [CoordW-1:0] r_cy;
    logic [RadW-1:0]          r_rad;
    logic [RowW-1:0]          r_row;
    logic [RowW-1:0]          r_final;
    logic                     r_miss;

    logic                     w_in_acc;
    logic signed [ExtW-1:0]   w_first;
    logic signed [ExtW-1:0]   w_final;
    logic                     w_miss;

    assign i_in.ready = !r_busy;
    assign w_in_acc   = i_in.valid && !r_busy;

    // Row range of the incoming circle
    always_comb begin
        w_first = ExtW'(i_in.center_y) - ExtW'(signed'({1'b0, i_in.radius}));
        w_final = ExtW'(i_in.center_y) + ExtW'(signed'({1'b0, i_in.radius}));
        if (w_first < 0) begin
            w_first = '0;
        end
        if (w_final > HMax) begin
            w_final = HMax;
        end
        w_miss = w_first > w_final;
    end

    // Current row setup
    logic                   n_last;
    logic signed [ExtW-1:0] n_d;
    logic [RadW-1:0]        n_ad;

    always_comb begin
        n_last = r_miss || (r_row == r_final);
        n_d    = ExtW'(r_cy) - ExtW'(signed'({1'b0, r_row}));
        n_ad   = n_d[ExtW-1] ? RadW'(-n_d) : RadW'(n_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_in_acc) begin
            r_busy <= 1'b1;
        end else if (r_busy && w_adv && n_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cx    <= i_in.center_x;
            r_cy    <= i_in.center_y;
            r_rad   <= i_in.radius;
            r_miss  <= w_miss;
            r_row   <= w_miss ? '0 : RowW'(w_first);
            r_final <= w_miss ? '0 : RowW'(w_final);
        end else if (r_busy && w_adv && !n_last) begin
            r_row <= r_row + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: row item with |d|
    // ------------------------------------------------------------------
    logic                     r_s1_vld;
    logic [RowW-1:0]          r_s1_row;
    logic signed [CoordW-1:0] r_s1_cx;
    logic                     r_s1_last;
    logic                     r_s1_miss;
    logic [RadW-1:0]          r_s1_ad;
    logic [RadW-1:0]          r_s1_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_row  <= r_row;
            r_s1_cx   <= r_cx;
            r_s1_last <= n_last;
            r_s1_miss <= r_miss;
            r_s1_ad   <= n_ad;
            r_s1_rad  <= r_rad;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: r^2 - d^2, then the square-root stages
    // ------------------------------------------------------------------
    t_root               r_pipe [RootStages+1];
    logic [RootStages:0] r_pvld;
    t_root               n_entry;
    t_root               n_step [RootStages];

    always_comb begin
        n_entry      = '0;
        n_entry.row  = r_s1_row;
        n_entry.cx   = r_s1_cx;
        n_entry.last = r_s1_last;
        n_entry.miss = r_s1_miss;
        n_entry.v    = SqW'(r_s1_rad) * SqW'(r_s1_rad) - SqW'(r_s1_ad) * SqW'(r_s1_ad);
    end

    // Two root steps per stage
    always_comb begin
        for (int s = 0; s < RootStages; s++) begin
            n_step[s] = r_pipe[s];
            for (int j = 0; j < StepsPerStg; j++) begin
                n_step[s] = sqrt_step(n_step[s], s * StepsPerStg + j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= '0;
        end else if (w_adv) begin
            r_pvld <= {r_pvld[RootStages-1:0], r_s1_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pipe[0] <= n_entry;
            for (int s = 0; s < RootStages; s++) begin
                r_pipe[s+1] <= n_step[s];
            end
        end
    end

    // ------------------------------------------------------------------
    // Span clip and output register
    // ------------------------------------------------------------------
    t_root                  w_fin;
    logic signed [ExtW-1:0] n_h;
    logic signed [ExtW-1:0] n_s;
    logic signed [ExtW-1:0] n_e;
    logic signed [ExtW-1:0] n_len;
    logic                   n_hit;

    assign w_fin = r_pipe[RootStages];

    always_comb begin
        n_h   = ExtW'(signed'({1'b0, w_fin.res[RadW-1:0]}));
        n_s   = ExtW'(w_fin.cx) - n_h;
        n_e   = ExtW'(w_fin.cx) + n_h;
        n_hit = !w_fin.miss && (n_s < WLim) && (n_e >= 0);
        if (n_s < 0) begin
            n_s = '0;
        end
        if (n_e > WMax) begin
            n_e = WMax;
        end
        n_len = n_e - n_s + ExtW'(1);
    end

    logic            r_out_vld;
    logic [RowW-1:0] r_out_row;
    logic [RowW-1:0] r_out_start;
    logic [LenW-1:0] r_out_len;
    logic            r_out_hit;
    logic            r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_pvld[RootStages];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_row   <= w_fin.miss ? '0 : w_fin.row;
            r_out_start <= n_hit ? RowW'(n_s) : '0;
            r_out_len   <= n_hit ? LenW'(n_len) : '0;
            r_out_hit   <= n_hit;
            r_out_last  <= w_fin.last;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.row         = r_out_row;
    assign o_out.span_start  = r_out_start;
    assign o_out.span_length = r_out_len;
    assign o_out.span_valid  = r_out_hit;
    assign o_out.last        = r_out_last;

endmodule

### rtl/csg_checker.sv
// ============================================================================
// csg_checker
// Port-level checks for the circle span clear generator, bound to the top.
// ============================================================================
module csg_checker
    import csg_pkg::*;
#(
    parameter int TILE_WIDTH  = 64,
    parameter int TILE_HEIGHT = 64
) (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input logic [RowW-1:0] i_row,
    input logic [RowW-1:0] i_span_start,
    input logic [LenW-1:0] i_span_length,
    input logic            i_span_valid,
    input logic            i_last
);

    logic [RowW+1:0] w_end;
    assign w_end = {2'b00, i_span_start} + {1'b0, i_span_length};

    // A held span transaction keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_row)
            && $stable(i_span_start) && $stable(i_span_length)
            && $stable(i_span_valid) && $stable(i_last))
        else $error("span transaction changed while stalled");

    // One circle at a time: no circle is taken right after another
    a_one_circle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("circle taken while previous one in flight");

    // An empty row carries no span
    a_empty_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_span_valid |-> i_span_start == '0 && i_span_length == '0)
        else $error("empty row with nonzero span");

    // A valid span lies inside the tile
    a_span_in_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_span_valid |-> i_span_length != '0
            && w_end <= (RowW+2)'(TILE_WIDTH)
            && {1'b0, i_row} < (RowW+1)'(TILE_HEIGHT))
        else $error("span outside tile");

endmodule

bind circle_span_clear_generator_core csg_checker #(
    .TILE_WIDTH  (TILE_WIDTH),
    .TILE_HEIGHT (TILE_HEIGHT)
) u_csg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_row         (o_out.row),
    .i_span_start  (o_out.span_start),
    .i_span_length (o_out.span_length),
    .i_span_valid  (o_out.span_valid),
    .i_last        (o_out.last)
);

### dv/tb_circle_span_clear_generator_core.sv
// ----------------------------------------------------------------------------
// tb_circle_span_clear_generator_core
// Self-checking bench for the circle span clear generator. Circles go in on
// a valid/ready channel and clear spans come out on another. Every accepted
// circle is expanded into its per-row spans by an integer model kept here;
// each span transaction is checked field by field against the oldest one
// still outstanding. Both channels idle at random, and the span side holds
// off once for a long stretch so the core backs up onto its circle input.
// ----------------------------------------------------------------------------
module tb_circle_span_clear_generator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import csg_pkg::*;

    localparam int TileW        = 64;
    localparam int TileH        = 64;
    localparam int RandCircles  = 310;
    localparam int CycleLimit   = 400000;
    localparam int TailCycles   = 24;
    // span-side long hold-off, keyed on the count of spans taken
    localparam int HoldAtSpan   = 1500;
    localparam int HoldCycles   = 600;
    // span-side stretch with ready held high
    localparam int SteadyFrom   = 3000;
    localparam int SteadyTo     = 4500;
    // circle-side stretch with no gaps, by random circle index
    localparam int BurstFrom    = 150;
    localparam int BurstTo      = 230;

    typedef struct packed {
        logic [RowW-1:0] row;
        logic [RowW-1:0] start;
        logic [LenW-1:0] len;
        logic            vld;
        logic            last;
    } span_t;

    // Expands circles into clear spans and matches them against the core
    class span_ledger;
        span_t expected_spans[$];
        int    mismatches;

        function int floor_root(int v);
            int h;
            int cand;
            h = 0;
            for (int b = 7; b >= 0; b--) begin
                cand = h | (1 << b);
                if (cand * cand <= v) h = cand;
            end
            return h;
        endfunction

        // cx, cy already sign-extended, r in 0..255
        function void note_circle(int cx, int cy, int r);
            int    top;
            int    bot;
            int    row;
            int    d;
            int    h;
            int    s;
            int    e;
            span_t sp;
            top = (cy - r < 0) ? 0 : cy - r;
            bot = (cy + r > TileH - 1) ? TileH - 1 : cy + r;
            // circle misses the tile vertically: one empty closing span
            if (top > bot) begin
                sp = '{row: '0, start: '0, len: '0, vld: 1'b0, last: 1'b1};
                expected_spans.push_back(sp);
                return;
            end
            for (row = top; row <= bot; row++) begin
                d  = cy - row;
                h  = (r * r >= d * d) ? floor_root(r * r - d * d) : 0;
                s  = cx - h;
                e  = cx + h;
                sp.row  = row[RowW-1:0];
                sp.last = (row == bot);
                if (s < TileW && e >= 0) begin
                    if (s < 0) s = 0;
                    if (e > TileW - 1) e = TileW - 1;
                    sp.start = s[RowW-1:0];
                    sp.len   = LenW'(e - s + 1);
                    sp.vld   = 1'b1;
                end else begin
                    sp.start = '0;
                    sp.len   = '0;
                    sp.vld   = 1'b0;
                end
                expected_spans.push_back(sp);
            end
        endfunction

        function void check_span(span_t got);
            span_t want;
            if (expected_spans.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected span: row=%0d start=%0d len=%0d valid=%0b last=%0b",
                             got.row, got.start, got.len, got.vld, got.last);
                return;
            end
            want = expected_spans.pop_front();
            if (got.row !== want.row || got.start !== want.start || got.len !== want.len
                    || got.vld !== want.vld || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("span mismatch: expected row=%0d start=%0d len=%0d valid=%0b last=%0b",
                             want.row, want.start, want.len, want.vld, want.last);
                    $display("               got      row=%0d start=%0d len=%0d valid=%0b last=%0b",
                             got.row, got.start, got.len, got.vld, got.last);
                end
            end
        endfunction

        function int pending();
            return expected_spans.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    csg_in_if  circle_if ();
    csg_out_if span_if ();

    span_ledger ledger = new();

    int cycles      = 0;
    int spans_taken = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    circle_span_clear_generator_core #(
        .TILE_WIDTH  (TileW),
        .TILE_HEIGHT (TileH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (circle_if),
        .o_out   (span_if)
    );

    // Clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("circle_span_clear_generator_core test failed");
            $finish;
        end
    end

    // Span side ready: random stalls, one long hold-off, one steady stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            span_if.ready <= 1'b0;
        end else begin
            if (span_if.valid && span_if.ready) spans_taken <= spans_taken + 1;
            if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                span_if.ready <= 1'b0;
            end else if (!hold_done && spans_taken >= HoldAtSpan) begin
                hold_done     <= 1'b1;
                hold_left     <= HoldCycles;
                span_if.ready <= 1'b0;
            end else if (spans_taken >= SteadyFrom && spans_taken < SteadyTo) begin
                span_if.ready <= 1'b1;
            end else begin
                span_if.ready <= ($urandom_range(0, 99) >= 10);
            end
        end
    end

    // Span monitor
    always @(posedge i_clk) begin
        span_t got;
        if (i_rst_n && span_if.valid && span_if.ready) begin
            got.row   = span_if.row;
            got.start = span_if.span_start;
            got.len   = span_if.span_length;
            got.vld   = span_if.span_valid;
            got.last  = span_if.last;
            ledger.check_span(got);
        end
    end

    // Offer one circle and hold it until taken, then maybe leave a gap
    task automatic send_circle(input int cx, input int cy, input int r, input bit may_idle);
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic [RadW-1:0]          rad;
        x   = cx[CoordW-1:0];
        y   = cy[CoordW-1:0];
        rad = r[RadW-1:0];
        circle_if.valid    <= 1'b1;
        circle_if.center_x <= x;
        circle_if.center_y <= y;
        circle_if.radius   <= rad;
        @(posedge i_clk);
        while (!circle_if.ready) @(posedge i_clk);
        ledger.note_circle(int'(x), int'(y), int'(rad));
        if (may_idle && $urandom_range(0, 99) < 25) begin
            circle_if.valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    endtask

    // Random circle: mostly near the tile, some hugging the edges, some anything
    task automatic random_circle(output int cx, output int cy, output int r);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            cx = $urandom_range(0, 150) - 40;
            cy = $urandom_range(0, 150) - 40;
            r  = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 40) : $urandom_range(41, 255);
        end else if (pick < 85) begin
            r  = $urandom_range(0, 70);
            cx = ($urandom_range(0, 1) != 0) ? -r + $urandom_range(0, 2) - 1
                                             : TileW - 1 + r - $urandom_range(0, 2) + 1;
            cy = ($urandom_range(0, 1) != 0) ? $urandom_range(0, TileH - 1)
                                             : $urandom_range(0, 1) ? -r : TileH - 1 + r;
        end else begin
            cx = $urandom_range(0, 1023) - 512;
            cy = $urandom_range(0, 1023) - 512;
            r  = $urandom_range(0, 255);
        end
    endtask

    // Directed circles: center, edges, misses, no-overlap rows, extremes
    int dir_cx[25] = '{  32,   0,  63,  -1,  64,  32,  32,  32, -512,  511,
                       -512,  511, -512,  511,  -5,  67,  20,  20,   10,   40,
                          0,   63, -200,  300,  32};
    int dir_cy[25] = '{  32,   0,  63,   5,   5,  -1,  64,  32, -512,  511,
                       -512, -512,  100,   20,  10,  10, -10,  73,   10,   50,
                         63,    0,   30,   30,  32};
    int dir_r[25]  = '{   0,   0,   0,   0,   0,   0,   0, 255,    0,  255,
                        255,  255,  255,  255,   5,   4,  10,  10,  255,   37,
                         64,   63,  250,  255, 100};

    // Main sequence
    initial begin
        int cx;
        int cy;
        int r;
        i_rst_n            <= 1'b0;
        circle_if.valid    <= 1'b0;
        circle_if.center_x <= '0;
        circle_if.center_y <= '0;
        circle_if.radius   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 25; i++) send_circle(dir_cx[i], dir_cy[i], dir_r[i], 1'b1);

        for (int i = 0; i < RandCircles; i++) begin
            random_circle(cx, cy, r);
            send_circle(cx, cy, r, !(i >= BurstFrom && i < BurstTo));
        end
        circle_if.valid <= 1'b0;

        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);

        if (ledger.mismatches == 0 && ledger.pending() == 0)
            $display("circle_span_clear_generator_core test passed");
        else
            $display("circle_span_clear_generator_core test failed");
        $finish;
    end

endmodule

### circle_span_clear_generator_core.f
rtl/csg_pkg.sv
rtl/csg_if.sv
rtl/circle_span_clear_generator_core.sv
rtl/csg_checker.sv
dv/tb_circle_span_clear_generator_core.sv
